// ===== rtl/r16ie_pkg.sv =====
`default_nettype none

package r16ie_pkg;

    localparam int MEM_WORDS = 4096;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int REG_COUNT = 8;
    localparam int REG_AW    = $clog2(REG_COUNT);

    localparam logic [1:0] OP_LOAD     = 2'd0;
    localparam logic [1:0] OP_EXEC     = 2'd1;
    localparam logic [1:0] OP_READ_MEM = 2'd2;
    localparam logic [1:0] OP_READ_REG = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MEM_RANGE = 2'd1;
    localparam logic [1:0] ST_REG_RANGE = 2'd2;
    localparam logic [1:0] ST_HALTED    = 2'd3;

    localparam logic [1:0] HALT_RUN  = 2'd0;
    localparam logic [1:0] HALT_STOP = 2'd1;
    localparam logic [1:0] HALT_EXIT = 2'd2;

    localparam logic [2:0] INS_ADD  = 3'd0;
    localparam logic [2:0] INS_ADDI = 3'd1;
    localparam logic [2:0] INS_NAND = 3'd2;
    localparam logic [2:0] INS_LUI  = 3'd3;
    localparam logic [2:0] INS_SW   = 3'd4;
    localparam logic [2:0] INS_LW   = 3'd5;
    localparam logic [2:0] INS_BEQ  = 3'd6;
    localparam logic [2:0] INS_JALR = 3'd7;

    localparam logic [6:0] SYSCALL_HALT = 7'd1;
    localparam logic [6:0] SYSCALL_EXIT = 7'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] address;
        logic [15:0] data_word;
    } in_item_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic [15:0] program_counter;
        logic [1:0]  halt_kind;
        logic [1:0]  status;
    } out_item_t;

    function automatic logic mem_ok(input logic [15:0] a);
        return {1'b0, a} < 17'(MEM_WORDS);
    endfunction

    function automatic logic reg_ok(input logic [15:0] a);
        return {1'b0, a} < 17'(REG_COUNT);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/r16ie_ram.sv =====
`default_nettype none

module r16ie_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] store [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            store[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= store[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/risc16_instruction_executor.sv =====
// 16-bit processor core with eight registers and a word memory, driven one
// transaction at a time over a valid/ready input channel (s_*) and a
// valid/ready result channel (m_*). Every input transaction yields exactly
// one result transaction, in order.
// The word memory is a synchronous RAM that is visited once for the instruction
// fetch and once more for lw/sw; the register file RAMs are read in S_DECODE.
// A load, and an execute while halted, finish in S_IDLE; a read passes through
// S_READ; an instruction passes through the fetch, S_DECODE and S_EXEC, and lw
// also through S_LW. One transaction is worked on at a time; the next is taken
// in the cycle its predecessor finishes, so loads run at one per cycle while
// the output register is free to take each result.
// A finished result waits in the output register; when the receiver stalls,
// the core still accepts one more transaction and holds it until the
// output register frees up, then it backs up through s_ready.
// Reset (aresetn low, synchronous) clears pc and halt state and starts a
// clearing pass that zeroes the word memory and registers, during which s_ready
// stays low.
`default_nettype none

module risc16_instruction_executor (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire r16ie_pkg::in_item_t  s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output r16ie_pkg::out_item_t      m_data
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_EXEC,
        S_LW,
        S_READ
    } state_t;

    state_t                        state_reg, state_next;
    logic [r16ie_pkg::MEM_AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic                          in_valid_reg, in_valid_next;
    r16ie_pkg::in_item_t           in_reg, in_next;
    logic                          out_valid_reg, out_valid_next;
    r16ie_pkg::out_item_t          out_reg, out_next;
    logic [15:0]                   pc_reg, pc_next;
    logic [1:0]                    halt_reg, halt_next;
    logic [15:0]                   ins_reg, ins_next;
    logic                          bad_reg, bad_next;

    logic                          done;
    logic                          out_free;
    r16ie_pkg::out_item_t          res;
    logic [15:0]                   ins_w;

    logic                          mem_we, mem_re;
    logic [r16ie_pkg::MEM_AW-1:0]  mem_waddr, mem_raddr;
    logic [15:0]                   mem_wdata, mem_rd_data;
    logic                          rf_we, rf_re_a, rf_re_b;
    logic [r16ie_pkg::REG_AW-1:0]  rf_waddr, rf_raddr_a, rf_raddr_b;
    logic [15:0]                   rf_wdata, rf_a_data, rf_b_data;

    logic [2:0]                    ins_opc, ins_ra, ins_rb;
    logic [6:0]                    ins_imm7;
    logic [15:0]                   ins_simm, ea, pc_inc;
    logic                          ea_ok;

    r16ie_ram #(.WIDTH(16), .DEPTH(r16ie_pkg::MEM_WORDS)) u_word_mem (
        .clk     (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rd_data)
    );

    // two copies of the register file give two read ports
    r16ie_ram #(.WIDTH(16), .DEPTH(r16ie_pkg::REG_COUNT)) u_rf_a (
        .clk     (aclk),
        .wr_en   (rf_we),
        .wr_addr (rf_waddr),
        .wr_data (rf_wdata),
        .rd_en   (rf_re_a),
        .rd_addr (rf_raddr_a),
        .rd_data (rf_a_data)
    );

    r16ie_ram #(.WIDTH(16), .DEPTH(r16ie_pkg::REG_COUNT)) u_rf_b (
        .clk     (aclk),
        .wr_en   (rf_we),
        .wr_addr (rf_waddr),
        .wr_data (rf_wdata),
        .rd_en   (rf_re_b),
        .rd_addr (rf_raddr_b),
        .rd_data (rf_b_data)
    );

    assign ins_opc  = ins_reg[15:13];
    assign ins_ra   = ins_reg[12:10];
    assign ins_rb   = ins_reg[9:7];
    assign ins_imm7 = ins_reg[6:0];
    assign ins_simm = {{9{ins_imm7[6]}}, ins_imm7};
    assign ea       = rf_a_data + ins_simm;
    assign ea_ok    = r16ie_pkg::mem_ok(ea);
    assign pc_inc   = pc_reg + 16'd1;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg != S_CLEAR) && (!in_valid_reg || done);
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        pc_next      = pc_reg;
        halt_next    = halt_reg;
        ins_next     = ins_reg;
        bad_next     = bad_reg;
        done         = 1'b0;
        res          = '0;
        ins_w        = '0;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = '0;
        rf_we        = 1'b0;
        rf_waddr     = '0;
        rf_wdata     = '0;
        rf_re_a      = 1'b0;
        rf_raddr_a   = '0;
        rf_re_b      = 1'b0;
        rf_raddr_b   = '0;

        case (state_reg)
            S_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                rf_we        = 1'b1;
                rf_waddr     = clr_cnt_reg[r16ie_pkg::REG_AW-1:0];
                clr_cnt_next = clr_cnt_reg + r16ie_pkg::MEM_AW'(1);
                if (clr_cnt_reg == r16ie_pkg::MEM_AW'(r16ie_pkg::MEM_WORDS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_valid_reg) begin
                    case (in_reg.operation)
                        r16ie_pkg::OP_LOAD: begin
                            if (out_free) begin
                                done = 1'b1;
                                if (r16ie_pkg::mem_ok(in_reg.address)) begin
                                    mem_we    = 1'b1;
                                    mem_waddr = in_reg.address[r16ie_pkg::MEM_AW-1:0];
                                    mem_wdata = in_reg.data_word;
                                end else begin
                                    res.status = r16ie_pkg::ST_MEM_RANGE;
                                end
                            end
                        end
                        r16ie_pkg::OP_EXEC: begin
                            if (halt_reg != r16ie_pkg::HALT_RUN) begin
                                if (out_free) begin
                                    done       = 1'b1;
                                    res.status = r16ie_pkg::ST_HALTED;
                                end
                            end else begin
                                bad_next   = !r16ie_pkg::mem_ok(pc_reg);
                                mem_re     = r16ie_pkg::mem_ok(pc_reg);
                                mem_raddr  = pc_reg[r16ie_pkg::MEM_AW-1:0];
                                state_next = S_DECODE;
                            end
                        end
                        r16ie_pkg::OP_READ_MEM: begin
                            mem_re     = r16ie_pkg::mem_ok(in_reg.address);
                            mem_raddr  = in_reg.address[r16ie_pkg::MEM_AW-1:0];
                            state_next = S_READ;
                        end
                        default: begin
                            rf_re_a    = r16ie_pkg::reg_ok(in_reg.address);
                            rf_raddr_a = in_reg.address[r16ie_pkg::REG_AW-1:0];
                            state_next = S_READ;
                        end
                    endcase
                end
            end
            S_DECODE: begin
                // an out-of-range fetch executes as add r0, r0, r0
                ins_w      = bad_reg ? 16'd0 : mem_rd_data;
                ins_next   = ins_w;
                rf_re_a    = 1'b1;
                rf_raddr_a = ins_w[9:7];
                rf_re_b    = 1'b1;
                if (ins_w[15:13] == r16ie_pkg::INS_ADD || ins_w[15:13] == r16ie_pkg::INS_NAND) begin
                    rf_raddr_b = ins_w[2:0];
                end else begin
                    rf_raddr_b = ins_w[12:10];
                end
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (ins_opc == r16ie_pkg::INS_LW) begin
                    mem_re     = ea_ok;
                    mem_raddr  = ea[r16ie_pkg::MEM_AW-1:0];
                    bad_next   = !ea_ok;
                    state_next = S_LW;
                end else if (out_free) begin
                    done       = 1'b1;
                    pc_next    = pc_inc;
                    res.status = bad_reg ? r16ie_pkg::ST_MEM_RANGE : r16ie_pkg::ST_OK;
                    rf_waddr   = ins_ra;
                    case (ins_opc)
                        r16ie_pkg::INS_ADD: begin
                            rf_we    = (ins_ra != 3'd0);
                            rf_wdata = rf_a_data + rf_b_data;
                        end
                        r16ie_pkg::INS_ADDI: begin
                            rf_we    = (ins_ra != 3'd0);
                            rf_wdata = ea;
                        end
                        r16ie_pkg::INS_NAND: begin
                            rf_we    = (ins_ra != 3'd0);
                            rf_wdata = ~(rf_a_data & rf_b_data);
                        end
                        r16ie_pkg::INS_LUI: begin
                            rf_we    = (ins_ra != 3'd0);
                            rf_wdata = {ins_reg[9:0], 6'd0};
                        end
                        r16ie_pkg::INS_SW: begin
                            if (ea_ok) begin
                                mem_we    = 1'b1;
                                mem_waddr = ea[r16ie_pkg::MEM_AW-1:0];
                                mem_wdata = rf_b_data;
                            end else begin
                                res.status = r16ie_pkg::ST_MEM_RANGE;
                            end
                        end
                        r16ie_pkg::INS_BEQ: begin
                            if (rf_a_data == rf_b_data) begin
                                pc_next = pc_inc + ins_simm;
                            end
                        end
                        r16ie_pkg::INS_JALR: begin
                            if (ins_imm7 == 7'd0) begin
                                rf_we    = (ins_ra != 3'd0);
                                rf_wdata = pc_inc;
                                // link lands first, so ra == rb jumps to pc + 1
                                if (ins_ra == ins_rb && ins_ra != 3'd0) begin
                                    pc_next = pc_inc;
                                end else begin
                                    pc_next = rf_a_data;
                                end
                            end else if (ins_imm7 == r16ie_pkg::SYSCALL_HALT ||
                                         ins_imm7 == r16ie_pkg::SYSCALL_EXIT) begin
                                halt_next = ins_imm7[1:0];
                                pc_next   = pc_reg;
                            end
                        end
                        default: begin
                            rf_we = 1'b0;
                        end
                    endcase
                end
            end
            S_LW: begin
                if (out_free) begin
                    done       = 1'b1;
                    pc_next    = pc_inc;
                    rf_we      = (ins_ra != 3'd0);
                    rf_waddr   = ins_ra;
                    rf_wdata   = bad_reg ? 16'd0 : mem_rd_data;
                    res.status = bad_reg ? r16ie_pkg::ST_MEM_RANGE : r16ie_pkg::ST_OK;
                end
            end
            S_READ: begin
                if (out_free) begin
                    done = 1'b1;
                    if (in_reg.operation == r16ie_pkg::OP_READ_MEM) begin
                        if (r16ie_pkg::mem_ok(in_reg.address)) begin
                            res.read_data = mem_rd_data;
                        end else begin
                            res.status = r16ie_pkg::ST_MEM_RANGE;
                        end
                    end else begin
                        if (r16ie_pkg::reg_ok(in_reg.address)) begin
                            res.read_data = rf_a_data;
                        end else begin
                            res.status = r16ie_pkg::ST_REG_RANGE;
                        end
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (done) begin
            res.program_counter = pc_next;
            res.halt_kind       = halt_next;
            state_next          = S_IDLE;
        end
    end

    always_comb begin
        in_next        = in_reg;
        in_valid_next  = in_valid_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (done) begin
            in_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            in_next       = s_data;
            in_valid_next = 1'b1;
        end
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (done) begin
            out_next       = res;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
            halt_reg      <= r16ie_pkg::HALT_RUN;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            pc_reg        <= pc_next;
            halt_reg      <= halt_next;
        end
        in_reg  <= in_next;
        out_reg <= out_next;
        ins_reg <= ins_next;
        bad_reg <= bad_next;
    end

`ifndef SYNTHESIS
    a_done_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> (!out_valid_reg || m_ready))
        else $error("result produced while output register is occupied");

    a_done_retires_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (done && !(s_valid && s_ready)) |=> !in_valid_reg)
        else $error("finished transaction not retired");

    a_no_r0_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (rf_we && state_reg != S_CLEAR) |-> (rf_waddr != '0))
        else $error("write to r0 after clearing pass");

    a_halt_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        (halt_reg != r16ie_pkg::HALT_RUN) |=> (halt_reg == $past(halt_reg)))
        else $error("halt state changed without reset");

    a_halt_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg == r16ie_pkg::HALT_RUN || halt_reg == r16ie_pkg::HALT_STOP ||
        halt_reg == r16ie_pkg::HALT_EXIT)
        else $error("illegal halt state");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_risc16_instruction_executor.sv =====
module tb_risc16_instruction_executor;

    import r16ie_pkg::*;

    class core_shadow;
        logic [15:0] mem [MEM_WORDS];
        logic [15:0] regs [REG_COUNT];
        logic [15:0] pc;
        logic [1:0]  halt;
        out_item_t   due_results [$];
        int          mismatches;

        function new();
            foreach (mem[i]) mem[i] = 16'd0;
            foreach (regs[i]) regs[i] = 16'd0;
            pc = 16'd0;
            halt = HALT_RUN;
            mismatches = 0;
        endfunction

        function bit in_range(logic [15:0] a);
            return int'(a) < MEM_WORDS;
        endfunction

        function logic [15:0] rd(logic [2:0] idx);
            return (idx == 3'd0) ? 16'd0 : regs[idx];
        endfunction

        function void wr(logic [2:0] idx, logic [15:0] v);
            if (idx != 3'd0) regs[idx] = v;
        endfunction

        function logic [1:0] run_instruction();
            logic [15:0] ins, simm, nxt, ea;
            logic [2:0]  opc, ra, rb, rc;
            logic [6:0]  imm7;
            logic [1:0]  st;
            st = ST_OK;
            if (in_range(pc)) begin
                ins = mem[pc];
            end else begin
                ins = 16'd0;
                st = ST_MEM_RANGE;
            end
            opc = ins[15:13];
            ra = ins[12:10];
            rb = ins[9:7];
            rc = ins[2:0];
            imm7 = ins[6:0];
            simm = {{9{imm7[6]}}, imm7};
            nxt = pc + 16'd1;
            case (opc)
                INS_ADD:  wr(ra, rd(rb) + rd(rc));
                INS_ADDI: wr(ra, rd(rb) + simm);
                INS_NAND: wr(ra, ~(rd(rb) & rd(rc)));
                INS_LUI:  wr(ra, {ins[9:0], 6'd0});
                INS_SW: begin
                    ea = rd(rb) + simm;
                    if (in_range(ea)) mem[ea] = rd(ra);
                    else st = ST_MEM_RANGE;
                end
                INS_LW: begin
                    ea = rd(rb) + simm;
                    if (in_range(ea)) begin
                        wr(ra, mem[ea]);
                    end else begin
                        wr(ra, 16'd0);
                        st = ST_MEM_RANGE;
                    end
                end
                INS_BEQ: begin
                    if (rd(ra) == rd(rb)) nxt = nxt + simm;
                end
                default: begin
                    // link goes in before the target is read
                    if (imm7 == 7'd0) begin
                        wr(ra, nxt);
                        nxt = rd(rb);
                    end else if (imm7 == SYSCALL_HALT || imm7 == SYSCALL_EXIT) begin
                        halt = (imm7 == SYSCALL_HALT) ? HALT_STOP : HALT_EXIT;
                        nxt = pc;
                    end
                end
            endcase
            pc = nxt;
            return st;
        endfunction

        function void apply_request(in_item_t req);
            out_item_t res;
            res = '0;
            res.status = ST_OK;
            case (req.operation)
                OP_LOAD: begin
                    if (in_range(req.address)) mem[req.address] = req.data_word;
                    else res.status = ST_MEM_RANGE;
                end
                OP_EXEC: begin
                    if (halt != HALT_RUN) res.status = ST_HALTED;
                    else res.status = run_instruction();
                end
                OP_READ_MEM: begin
                    if (in_range(req.address)) res.read_data = mem[req.address];
                    else res.status = ST_MEM_RANGE;
                end
                default: begin
                    if (int'(req.address) < REG_COUNT) res.read_data = rd(req.address[2:0]);
                    else res.status = ST_REG_RANGE;
                end
            endcase
            res.program_counter = pc;
            res.halt_kind = halt;
            due_results.push_back(res);
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t %s mismatch: expected %h, actual %h", $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void match_result(out_item_t got);
            out_item_t want;
            if (due_results.size() == 0) begin
                $display("%0t unexpected result transaction %h", $time, got);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("program_counter", want.program_counter, got.program_counter);
            compare_field("halt_kind", 16'(want.halt_kind), 16'(got.halt_kind));
            compare_field("status", 16'(want.status), 16'(got.status));
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    core_shadow shadow = new();
    int idle_pct;
    int stall_pct;
    int sent_items;

    risc16_instruction_executor u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) shadow.match_result(m_data);
    end

    initial begin
        #3000000;
        $display("tb_risc16_instruction_executor NOT OK");
        $finish;
    end

    function automatic logic [15:0] enc(logic [2:0] opc, logic [2:0] ra, logic [2:0] rb,
                                        logic [6:0] imm7);
        return {opc, ra, rb, imm7};
    endfunction

    function automatic logic [15:0] gen_ins();
        logic [2:0] opc, ra, rb;
        logic [6:0] imm7;
        opc = 3'($urandom_range(0, 7));
        ra = 3'($urandom);
        rb = 3'($urandom);
        imm7 = 7'($urandom);
        case (opc)
            INS_ADDI: if ($urandom_range(0, 1)) rb = 3'd0;
            INS_LUI:  if ($urandom_range(0, 1)) {rb, imm7} = 10'($urandom_range(0, 63));
            INS_JALR: imm7 = ($urandom_range(0, 3) != 0) ? 7'd0 : 7'($urandom_range(3, 127));
            default: ;
        endcase
        return enc(opc, ra, rb, imm7);
    endfunction

    // keeps the core running and the pc inside memory
    function automatic bit is_safe(logic [15:0] ins);
        logic [15:0] nxt, tgt;
        logic [6:0]  imm7;
        logic [2:0]  ra, rb;
        imm7 = ins[6:0];
        ra = ins[12:10];
        rb = ins[9:7];
        nxt = shadow.pc + 16'd1;
        tgt = nxt;
        if (ins[15:13] == INS_BEQ && shadow.rd(ra) == shadow.rd(rb)) begin
            tgt = nxt + {{9{imm7[6]}}, imm7};
        end else if (ins[15:13] == INS_JALR) begin
            if (imm7 == SYSCALL_HALT || imm7 == SYSCALL_EXIT) return 1'b0;
            if (imm7 == 7'd0) tgt = (ra == rb && ra != 3'd0) ? nxt : shadow.rd(rb);
        end
        return shadow.in_range(tgt);
    endfunction

    function automatic logic [15:0] pick_addr();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 63));
            1: return 16'($urandom_range(0, MEM_WORDS - 1));
            2: return 16'($urandom_range(MEM_WORDS - 4, MEM_WORDS + 3));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send(input logic [1:0] op, input logic [15:0] addr, input logic [15:0] data);
        in_item_t req;
        req.operation = op;
        req.address = addr;
        req.data_word = data;
        if ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        do @(posedge aclk); while (!(s_valid && s_ready));
        shadow.apply_request(req);
        sent_items++;
        @(negedge aclk);
    endtask

    task automatic exec_ins(input logic [15:0] ins);
        send(OP_LOAD, shadow.pc, ins);
        send(OP_EXEC, 16'($urandom), 16'($urandom));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (shadow.pending() != 0) @(negedge aclk);
    endtask

    int phase_idle [4] = '{0, 65, 0, 22};
    int phase_stall [4] = '{0, 0, 65, 22};

    initial begin
        int sel;
        int phase_end;
        logic [15:0] ins;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        sent_items = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: range checks, every instruction, special cases
        send(OP_READ_REG, 16'd8, 16'd0);
        send(OP_LOAD, 16'hFFFF, 16'hFFFF);
        send(OP_LOAD, 16'(MEM_WORDS - 1), 16'hFFFF);
        send(OP_READ_MEM, 16'(MEM_WORDS), 16'd0);
        exec_ins(enc(INS_LUI, 3'd1, 3'd7, 7'h7F));
        exec_ins(enc(INS_ADDI, 3'd1, 3'd1, 7'd62));
        exec_ins(enc(INS_ADD, 3'd3, 3'd1, 7'd1));
        exec_ins(enc(INS_NAND, 3'd4, 3'd1, 7'd3));
        exec_ins(enc(INS_SW, 3'd1, 3'd0, 7'd10));
        exec_ins(enc(INS_LW, 3'd5, 3'd0, 7'd10));
        exec_ins(enc(INS_SW, 3'd1, 3'd1, 7'd0));
        exec_ins(enc(INS_LW, 3'd6, 3'd0, 7'h7F));
        exec_ins(enc(INS_ADDI, 3'd0, 3'd1, 7'd5));
        exec_ins(enc(INS_BEQ, 3'd0, 3'd0, 7'd2));
        exec_ins(enc(INS_JALR, 3'd0, 3'd0, 7'd3));
        exec_ins(enc(INS_JALR, 3'd2, 3'd2, 7'd0));
        exec_ins(enc(INS_JALR, 3'd7, 3'd1, 7'd0));
        // fetches from beyond memory until the pc wraps to zero
        send(OP_EXEC, 16'd0, 16'd0);
        send(OP_EXEC, 16'hFFFF, 16'hFFFF);
        drain();

        for (int p = 0; p < 4; p++) begin
            idle_pct = phase_idle[p];
            stall_pct = phase_stall[p];
            phase_end = sent_items + 440;
            while (sent_items < phase_end) begin
                sel = $urandom_range(0, 99);
                if (sel < 60) begin
                    if ($urandom_range(0, 9) < 7 || !is_safe(shadow.mem[shadow.pc])) begin
                        do ins = gen_ins(); while (!is_safe(ins));
                        send(OP_LOAD, shadow.pc, ins);
                    end
                    send(OP_EXEC, 16'($urandom), 16'($urandom));
                end else if (sel < 75) begin
                    send(OP_LOAD, pick_addr(), 16'($urandom));
                end else if (sel < 88) begin
                    send(OP_READ_MEM, pick_addr(), 16'($urandom));
                end else begin
                    send(OP_READ_REG,
                         ($urandom_range(0, 6) != 0) ? 16'($urandom_range(0, 7)) : 16'($urandom),
                         16'($urandom));
                end
            end
            drain();
        end

        // system call, then the halted core
        exec_ins(enc(INS_JALR, 3'($urandom), 3'($urandom),
                     $urandom_range(0, 1) ? SYSCALL_HALT : SYSCALL_EXIT));
        send(OP_EXEC, 16'd0, 16'd0);
        send(OP_READ_REG, 16'd1, 16'd0);
        send(OP_LOAD, 16'd20, 16'($urandom));
        send(OP_READ_MEM, 16'd20, 16'd0);
        s_valid <= 1'b0;
        stall_pct = 0;

        while (shadow.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (shadow.mismatches == 0) begin
            $display("tb_risc16_instruction_executor OK");
        end else begin
            $display("tb_risc16_instruction_executor NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/r16ie_pkg.sv
rtl/r16ie_ram.sv
rtl/risc16_instruction_executor.sv
tb/sv/tb_risc16_instruction_executor.sv
